// ===== hdl/cau_pkg.sv =====
// ============================================================================
// cau_pkg
// Shared constants, mode codes, pipeline slot types and the saturation helper
// for the complex arithmetic unit.
// ============================================================================
package cau_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int MODE_W       = 3;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int QUO_W        = DATA_W;
    localparam int SQRT_STEPS   = DATA_W;
    localparam int ANGLE_FRAC   = 30;
    localparam int ANGLE_W      = 34;
    localparam int CORDIC_STEPS = 31;
    localparam int NORM_STAGES  = 6;
    localparam int NORM_EXP     = 59;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [PROD_W-1:0] LIM_POS = PROD_W'((65'd1 << (DATA_W - 1)) - 65'd1);
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(65'd1 << (DATA_W - 1));
    localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W - 1){1'b0}}};

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
        32'h00000000
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 3'd0,
        MODE_SUB   = 3'd1,
        MODE_MUL   = 3'd2,
        MODE_DIV   = 3'd3,
        MODE_MAG   = 3'd4,
        MODE_PHASE = 3'd5
    } mode_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } clamp_t;

    typedef struct packed {
        logic [PROD_W-1:0] den;
        logic [PROD_W-1:0] rem_re;
        logic [PROD_W-1:0] rem_im;
        logic [QUO_W-1:0]  bits_re;
        logic [QUO_W-1:0]  bits_im;
    } div_slot_t;

    typedef struct packed {
        logic [PROD_W-1:0] rad;
        logic [PROD_W-1:0] root;
    } sqrt_slot_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]  x;
        logic signed [PROD_W-1:0]  y;
        logic signed [ANGLE_W-1:0] z;
    } cordic_slot_t;

    typedef struct packed {
        mode_t             mode;
        logic [DATA_W-1:0] fast_re;
        logic [DATA_W-1:0] fast_im;
        logic              fast_sat;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic              dz;
        logic              zero_vec;
    } side_t;

    // Sign and magnitude to a clamped two's complement value.
    function automatic clamp_t clamp_part(input logic neg, input logic [PROD_W-1:0] mag);
        clamp_t r;
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > LIM_POS) begin
                r.val = MAX_VAL;
                r.sat = 1'b1;
            end else begin
                r.val = mag[DATA_W-1:0];
            end
        end else begin
            if (mag > LIM_NEG) begin
                r.val = MIN_VAL;
                r.sat = 1'b1;
            end else begin
                r.val = -mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
// ============================================================================
// complex_arithmetic_unit
// Pipelined complex ALU on signed Q16.16: add, subtract, multiply, divide,
// magnitude and phase, with saturation and divide-by-zero flags.
// ============================================================================
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+----------------------------------------
//  input    | in  | s_valid / s_ready  | s_mode, s_a_re, s_a_im, s_b_re, s_b_im
//  result   | out | m_valid / m_ready  | m_res_re, m_res_im, m_div_zero,
//           |     |                    | m_saturated
//
//  One transfer per cycle in each direction, sustained while m_ready stays high.
//  The depth from an input transfer to m_valid is the same for every mode and
//  is set by the phase path after the input register: one pre-rotation stage,
//  six normalize stages, a row of 31 CORDIC cells and the output register.
//  The divide and square-root rows are 32 cells each and are padded to the same depth.
//  aresetn is synchronous and active low; it clears only the valid bits.
//  When a result waits on m_ready, the whole row of cells holds; s_ready drops at
//  once if the input register is full, else it takes one more transfer first.
//
module complex_arithmetic_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [cau_pkg::MODE_W-1:0]  s_mode,
    input  logic signed [cau_pkg::DATA_W-1:0]  s_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0]  s_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0]  s_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0]  s_b_im,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [cau_pkg::DATA_W-1:0]  m_res_re,
    output logic signed [cau_pkg::DATA_W-1:0]  m_res_im,
    output logic                               m_div_zero,
    output logic                               m_saturated
);
    import cau_pkg::*;

    // Pipeline positions: 0 input register, 1 products, 2 sums, 3 prep.
    localparam int P3_POS    = 3;
    localparam int CHAIN_END = 1 + NORM_STAGES + CORDIC_STEPS;
    localparam int ARITH_END = P3_POS + QUO_W;
    localparam int ARITH_PAD = CHAIN_END - ARITH_END;
    localparam int SIDE_LEN  = CHAIN_END - P3_POS + 1;

    // Wrap a widened sum back to the data width with saturation.
    function automatic clamp_t sum_sat(input logic [DATA_W:0] s);
        clamp_t r;
        r.sat = s[DATA_W] != s[DATA_W-1];
        if (r.sat) begin
            r.val = s[DATA_W] ? MIN_VAL : MAX_VAL;
        end else begin
            r.val = s[DATA_W-1:0];
        end
        return r;
    endfunction

    logic en;

    // ---------------- input register ----------------
    logic                     in_valid_reg;
    mode_t                    in_mode_reg;
    logic signed [DATA_W-1:0] in_a_re_reg, in_a_im_reg, in_b_re_reg, in_b_im_reg;

    // The whole row advances when the output register is free or being drained.
    assign en      = !m_valid || m_ready;
    assign s_ready = en || !in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= mode_t'(s_mode);
            in_a_re_reg <= s_a_re;
            in_a_im_reg <= s_a_im;
            in_b_re_reg <= s_b_re;
            in_b_im_reg <= s_b_im;
        end
    end

    // ---------------- stage 1: products, add/sub, pre-rotation ----------------
    logic                     p1_valid_reg;
    mode_t                    p1_mode_reg;
    logic signed [PROD_W-1:0] p1_rr_reg, p1_ii_reg, p1_ri_reg, p1_ir_reg;
    logic signed [PROD_W-1:0] p1_bbr_reg, p1_bbi_reg, p1_aar_reg, p1_aai_reg;
    clamp_t                   p1_as_re_reg, p1_as_im_reg;
    cordic_slot_t             p1_cord_reg;
    logic                     p1_zero_reg;

    logic [DATA_W:0]          sum_re, sum_im;
    logic signed [DATA_W:0]   ax, ay;
    cordic_slot_t             cord_next;

    always_comb begin
        if (in_mode_reg == MODE_SUB) begin
            sum_re = {in_a_re_reg[DATA_W-1], in_a_re_reg} - {in_b_re_reg[DATA_W-1], in_b_re_reg};
            sum_im = {in_a_im_reg[DATA_W-1], in_a_im_reg} - {in_b_im_reg[DATA_W-1], in_b_im_reg};
        end else begin
            sum_re = {in_a_re_reg[DATA_W-1], in_a_re_reg} + {in_b_re_reg[DATA_W-1], in_b_re_reg};
            sum_im = {in_a_im_reg[DATA_W-1], in_a_im_reg} + {in_b_im_reg[DATA_W-1], in_b_im_reg};
        end
    end

    // Turn a left-half vector by a quarter turn so CORDIC starts with x >= 0.
    always_comb begin
        ax = (DATA_W + 1)'(in_a_re_reg);
        ay = (DATA_W + 1)'(in_a_im_reg);
        if (ax < 0) begin
            if (ay >= 0) begin
                cord_next.x = PROD_W'(ay);
                cord_next.y = PROD_W'(-ax);
                cord_next.z = HALF_PI_Q30;
            end else begin
                cord_next.x = PROD_W'(-ay);
                cord_next.y = PROD_W'(ax);
                cord_next.z = -HALF_PI_Q30;
            end
        end else begin
            cord_next.x = PROD_W'(ax);
            cord_next.y = PROD_W'(ay);
            cord_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_mode_reg  <= in_mode_reg;
            p1_rr_reg    <= in_a_re_reg * in_b_re_reg;
            p1_ii_reg    <= in_a_im_reg * in_b_im_reg;
            p1_ri_reg    <= in_a_re_reg * in_b_im_reg;
            p1_ir_reg    <= in_a_im_reg * in_b_re_reg;
            p1_bbr_reg   <= in_b_re_reg * in_b_re_reg;
            p1_bbi_reg   <= in_b_im_reg * in_b_im_reg;
            p1_aar_reg   <= in_a_re_reg * in_a_re_reg;
            p1_aai_reg   <= in_a_im_reg * in_a_im_reg;
            p1_as_re_reg <= sum_sat(sum_re);
            p1_as_im_reg <= sum_sat(sum_im);
            p1_cord_reg  <= cord_next;
            p1_zero_reg  <= (in_a_re_reg == '0) && (in_a_im_reg == '0);
        end
    end

    // ---------------- stage 2: sums of products ----------------
    logic                    p2_valid_reg;
    mode_t                   p2_mode_reg;
    logic signed [ACC_W-1:0] p2_mre_reg, p2_mim_reg, p2_nre_reg, p2_nim_reg;
    logic [PROD_W-1:0]       p2_den_reg, p2_rad_reg;
    clamp_t                  p2_as_re_reg, p2_as_im_reg;
    logic                    p2_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_mode_reg  <= p1_mode_reg;
            p2_mre_reg   <= {p1_rr_reg[PROD_W-1], p1_rr_reg} - {p1_ii_reg[PROD_W-1], p1_ii_reg};
            p2_mim_reg   <= {p1_ri_reg[PROD_W-1], p1_ri_reg} + {p1_ir_reg[PROD_W-1], p1_ir_reg};
            p2_nre_reg   <= {p1_rr_reg[PROD_W-1], p1_rr_reg} + {p1_ii_reg[PROD_W-1], p1_ii_reg};
            p2_nim_reg   <= {p1_ir_reg[PROD_W-1], p1_ir_reg} - {p1_ri_reg[PROD_W-1], p1_ri_reg};
            p2_den_reg   <= $unsigned(p1_bbr_reg) + $unsigned(p1_bbi_reg);
            p2_rad_reg   <= $unsigned(p1_aar_reg) + $unsigned(p1_aai_reg);
            p2_as_re_reg <= p1_as_re_reg;
            p2_as_im_reg <= p1_as_im_reg;
            p2_zero_reg  <= p1_zero_reg;
        end
    end

    // ---------------- stage 3: multiply finish, divide and root setup ----------------
    logic [ACC_W-1:0]  mag_mre, mag_mim, mag_nre, mag_nim;
    logic [PROD_W-1:0] num_re, num_im, rem0_re, rem0_im;
    clamp_t            mul_re, mul_im;
    side_t             side_next;
    div_slot_t         div_next;

    always_comb begin
        mag_mre = p2_mre_reg[ACC_W-1] ? -p2_mre_reg : p2_mre_reg;
        mag_mim = p2_mim_reg[ACC_W-1] ? -p2_mim_reg : p2_mim_reg;
        mag_nre = p2_nre_reg[ACC_W-1] ? -p2_nre_reg : p2_nre_reg;
        mag_nim = p2_nim_reg[ACC_W-1] ? -p2_nim_reg : p2_nim_reg;
        mul_re  = clamp_part(p2_mre_reg[ACC_W-1], PROD_W'(mag_mre >> FRAC_W));
        mul_im  = clamp_part(p2_mim_reg[ACC_W-1], PROD_W'(mag_mim >> FRAC_W));
        num_re  = mag_nre[PROD_W-1:0];
        num_im  = mag_nim[PROD_W-1:0];
        // Numerator is num << FRAC_W; its upper part seeds the remainder.
        rem0_re = num_re >> (QUO_W - FRAC_W);
        rem0_im = num_im >> (QUO_W - FRAC_W);

        div_next.den     = p2_den_reg;
        div_next.rem_re  = rem0_re;
        div_next.rem_im  = rem0_im;
        div_next.bits_re = {num_re[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        div_next.bits_im = {num_im[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

        side_next.mode     = p2_mode_reg;
        side_next.neg_re   = p2_nre_reg[ACC_W-1];
        side_next.neg_im   = p2_nim_reg[ACC_W-1];
        // Quotient would need more than QUO_W bits: saturate.
        side_next.ovf_re   = rem0_re >= p2_den_reg;
        side_next.ovf_im   = rem0_im >= p2_den_reg;
        side_next.dz       = p2_den_reg == '0;
        side_next.zero_vec = p2_zero_reg;
        unique case (p2_mode_reg)
            MODE_ADD, MODE_SUB: begin
                side_next.fast_re  = p2_as_re_reg.val;
                side_next.fast_im  = p2_as_im_reg.val;
                side_next.fast_sat = p2_as_re_reg.sat | p2_as_im_reg.sat;
            end
            MODE_MUL: begin
                side_next.fast_re  = mul_re.val;
                side_next.fast_im  = mul_im.val;
                side_next.fast_sat = mul_re.sat | mul_im.sat;
            end
            default: begin
                side_next.fast_re  = '0;
                side_next.fast_im  = '0;
                side_next.fast_sat = 1'b0;
            end
        endcase
    end

    div_slot_t  p3_div_reg;
    sqrt_slot_t p3_sqrt_reg;
    side_t      side_reg  [SIDE_LEN];
    logic       valid_reg [SIDE_LEN];

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_div_reg       <= div_next;
            p3_sqrt_reg.rad  <= p2_rad_reg;
            p3_sqrt_reg.root <= '0;
        end
    end

    // Mode, flags and short results ride alongside the long rows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SIDE_LEN; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= p2_valid_reg;
            for (int k = 1; k < SIDE_LEN; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_LEN; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- divide and square-root rows ----------------
    div_slot_t  div_pipe  [QUO_W+1];
    sqrt_slot_t sqrt_pipe [SQRT_STEPS+1];

    assign div_pipe[0]  = p3_div_reg;
    assign sqrt_pipe[0] = p3_sqrt_reg;

    genvar gk;
    generate
        for (gk = 0; gk < QUO_W; gk++) begin : g_div
            cau_div_cell u_div_cell (
                .aclk     (aclk),
                .en       (en),
                .slot_in  (div_pipe[gk]),
                .slot_out (div_pipe[gk+1])
            );
        end
        for (gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
            cau_sqrt_cell #(.STEP(gk)) u_sqrt_cell (
                .aclk     (aclk),
                .en       (en),
                .slot_in  (sqrt_pipe[gk]),
                .slot_out (sqrt_pipe[gk+1])
            );
        end
    endgenerate

    // Hold quotients and root until the phase row catches up.
    logic [QUO_W-1:0]  q_re_pad_reg [ARITH_PAD];
    logic [QUO_W-1:0]  q_im_pad_reg [ARITH_PAD];
    logic [DATA_W-1:0] root_pad_reg [ARITH_PAD];

    always_ff @(posedge aclk) begin
        if (en) begin
            q_re_pad_reg[0] <= div_pipe[QUO_W].bits_re;
            q_im_pad_reg[0] <= div_pipe[QUO_W].bits_im;
            root_pad_reg[0] <= sqrt_pipe[SQRT_STEPS].root[DATA_W-1:0];
            for (int k = 1; k < ARITH_PAD; k++) begin
                q_re_pad_reg[k] <= q_re_pad_reg[k-1];
                q_im_pad_reg[k] <= q_im_pad_reg[k-1];
                root_pad_reg[k] <= root_pad_reg[k-1];
            end
        end
    end

    // ---------------- normalize, then CORDIC row ----------------
    // Binary search for the doubling count that lifts the larger part to 2^59.
    cordic_slot_t norm_reg [NORM_STAGES];

    genvar gj;
    generate
        for (gj = 0; gj < NORM_STAGES; gj++) begin : g_norm
            localparam int SH = 1 << (NORM_STAGES - 1 - gj);
            localparam logic signed [PROD_W-1:0] LIM = PROD_W'(1) << (NORM_EXP + 1 - SH);
            cordic_slot_t cur;
            logic         grow;

            if (gj == 0) begin : g_first
                assign cur = p1_cord_reg;
            end else begin : g_rest
                assign cur = norm_reg[gj-1];
            end

            assign grow = (cur.x < LIM) && (cur.y < LIM) && (cur.y > -LIM);

            always_ff @(posedge aclk) begin
                if (en) begin
                    norm_reg[gj].x <= grow ? (cur.x <<< SH) : cur.x;
                    norm_reg[gj].y <= grow ? (cur.y <<< SH) : cur.y;
                    norm_reg[gj].z <= cur.z;
                end
            end
        end
    endgenerate

    cordic_slot_t cord_pipe [CORDIC_STEPS+1];

    assign cord_pipe[0] = norm_reg[NORM_STAGES-1];

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
            cau_cordic_cell #(.STEP(gi)) u_cordic_cell (
                .aclk     (aclk),
                .en       (en),
                .slot_in  (cord_pipe[gi]),
                .slot_out (cord_pipe[gi+1])
            );
        end
    endgenerate

    // ---------------- result select and output register ----------------
    side_t                     side_end;
    clamp_t                    div_re, div_im, mag_res;
    logic [ANGLE_W-1:0]        z_mag;
    logic [DATA_W-1:0]         z_trunc, phase_val;
    logic signed [ANGLE_W-1:0] z_end;
    logic [DATA_W-1:0]         res_re_next, res_im_next;
    logic                      dz_next, sat_next;

    assign side_end = side_reg[SIDE_LEN-1];

    always_comb begin
        div_re  = clamp_part(side_end.neg_re,
                             side_end.ovf_re ? '1 : PROD_W'(q_re_pad_reg[ARITH_PAD-1]));
        div_im  = clamp_part(side_end.neg_im,
                             side_end.ovf_im ? '1 : PROD_W'(q_im_pad_reg[ARITH_PAD-1]));
        mag_res = clamp_part(1'b0, PROD_W'(root_pad_reg[ARITH_PAD-1]));

        // Truncate the Q4.30 angle toward zero to the output fraction.
        z_end     = cord_pipe[CORDIC_STEPS].z;
        z_mag     = z_end[ANGLE_W-1] ? -z_end : z_end;
        z_trunc   = DATA_W'(z_mag >> (ANGLE_FRAC - FRAC_W));
        phase_val = z_end[ANGLE_W-1] ? -z_trunc : z_trunc;

        res_re_next = '0;
        res_im_next = '0;
        dz_next     = 1'b0;
        sat_next    = 1'b0;
        unique case (side_end.mode)
            MODE_ADD, MODE_SUB, MODE_MUL: begin
                res_re_next = side_end.fast_re;
                res_im_next = side_end.fast_im;
                sat_next    = side_end.fast_sat;
            end
            MODE_DIV: begin
                if (side_end.dz) begin
                    dz_next = 1'b1;
                end else begin
                    res_re_next = div_re.val;
                    res_im_next = div_im.val;
                    sat_next    = div_re.sat | div_im.sat;
                end
            end
            MODE_MAG: begin
                res_re_next = mag_res.val;
                sat_next    = mag_res.sat;
            end
            MODE_PHASE: begin
                res_re_next = side_end.zero_vec ? '0 : phase_val;
            end
            default: begin
                res_re_next = '0;
            end
        endcase
    end

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_res_re_reg, m_res_im_reg;
    logic                     m_div_zero_reg, m_saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_reg[SIDE_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_re_reg    <= res_re_next;
            m_res_im_reg    <= res_im_next;
            m_div_zero_reg  <= dz_next;
            m_saturated_reg <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_res_re    = m_res_re_reg;
    assign m_res_im    = m_res_im_reg;
    assign m_div_zero  = m_div_zero_reg;
    assign m_saturated = m_saturated_reg;

endmodule

// ===== hdl/cau_div_cell.sv =====
// ============================================================================
// cau_div_cell
// One restoring division step for the real and imaginary quotients.
// ============================================================================
module cau_div_cell (
    input  logic                aclk,
    input  logic                en,
    input  cau_pkg::div_slot_t  slot_in,
    output cau_pkg::div_slot_t  slot_out
);
    import cau_pkg::*;

    logic [PROD_W:0] trial_re, trial_im;
    logic [PROD_W:0] diff_re, diff_im;
    logic            q_re, q_im;
    div_slot_t       slot_next;
    div_slot_t       slot_reg;

    always_comb begin
        trial_re = {slot_in.rem_re, slot_in.bits_re[QUO_W-1]};
        trial_im = {slot_in.rem_im, slot_in.bits_im[QUO_W-1]};
        diff_re  = trial_re - {1'b0, slot_in.den};
        diff_im  = trial_im - {1'b0, slot_in.den};
        q_re     = trial_re >= {1'b0, slot_in.den};
        q_im     = trial_im >= {1'b0, slot_in.den};
        slot_next.den     = slot_in.den;
        slot_next.rem_re  = q_re ? diff_re[PROD_W-1:0] : trial_re[PROD_W-1:0];
        slot_next.rem_im  = q_im ? diff_im[PROD_W-1:0] : trial_im[PROD_W-1:0];
        slot_next.bits_re = {slot_in.bits_re[QUO_W-2:0], q_re};
        slot_next.bits_im = {slot_in.bits_im[QUO_W-2:0], q_im};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ===== hdl/cau_sqrt_cell.sv =====
// ============================================================================
// cau_sqrt_cell
// One digit step of the integer square root; STEP selects the bit weight.
// ============================================================================
module cau_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  cau_pkg::sqrt_slot_t  slot_in,
    output cau_pkg::sqrt_slot_t  slot_out
);
    import cau_pkg::*;

    localparam logic [PROD_W-1:0] WEIGHT = PROD_W'(1) << (PROD_W - 2 - 2 * STEP);

    logic [PROD_W-1:0] trial;
    sqrt_slot_t        slot_next;
    sqrt_slot_t        slot_reg;

    always_comb begin
        trial = slot_in.root + WEIGHT;
        if (slot_in.rad >= trial) begin
            slot_next.rad  = slot_in.rad - trial;
            slot_next.root = (slot_in.root >> 1) + WEIGHT;
        end else begin
            slot_next.rad  = slot_in.rad;
            slot_next.root = slot_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ===== hdl/cau_cordic_cell.sv =====
// ============================================================================
// cau_cordic_cell
// One vectoring CORDIC micro-rotation; STEP selects shift and angle.
// ============================================================================
module cau_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                   aclk,
    input  logic                   en,
    input  cau_pkg::cordic_slot_t  slot_in,
    output cau_pkg::cordic_slot_t  slot_out
);
    import cau_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ANG = {2'b00, ATAN_TAB[STEP]};

    logic signed [PROD_W-1:0] cur_x, cur_y, dx, dy;
    cordic_slot_t             slot_next;
    cordic_slot_t             slot_reg;

    always_comb begin
        cur_x = slot_in.x;
        cur_y = slot_in.y;
        dx    = cur_x >>> STEP;
        dy    = cur_y >>> STEP;
        if (!cur_y[PROD_W-1]) begin
            slot_next.x = cur_x + dy;
            slot_next.y = cur_y - dx;
            slot_next.z = slot_in.z + ANG;
        end else begin
            slot_next.x = cur_x - dy;
            slot_next.y = cur_y + dx;
            slot_next.z = slot_in.z - ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ===== hdl/cau_checker.sv =====
// ============================================================================
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ============================================================================
module cau_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [cau_pkg::DATA_W-1:0]  m_res_re,
    input logic signed [cau_pkg::DATA_W-1:0]  m_res_im,
    input logic                               m_div_zero,
    input logic                               m_saturated
);
    import cau_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_res_re) && $stable(m_res_im)
                                && $stable(m_div_zero) && $stable(m_saturated))
        else $error("stalled result changed");

    // Input back-pressure only comes from a blocked result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    a_dz_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero |-> m_res_re == '0 && m_res_im == '0 && !m_saturated)
        else $error("divide by zero result not cleared");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_res_re    (m_res_re),
    .m_res_im    (m_res_im),
    .m_div_zero  (m_div_zero),
    .m_saturated (m_saturated)
);

// ===== sim/complex_arithmetic_unit_test.sv =====
// ============================================================================
// complex_arithmetic_unit_test
// Self-checking bench for the complex ALU. It sends directed corner cases and
// then random operand pairs in every mode. Gaps are drawn on the input side and
// stalls on the result side, with one long receiver hold-off. Each result is
// checked field by field against an in-bench fixed-point predictor.
// ============================================================================
module complex_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  MAX_REPORTS = 10;
    localparam int  N_MODES     = 6;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct {
        mode_t mode;
        word_t re;
        word_t im;
        logic  dz;
        logic  sat;
    } alu_result_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    logic  [MODE_W-1:0] s_mode = '0;
    word_t s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    word_t m_res_re, m_res_im;
    logic  m_div_zero, m_saturated;

    alu_result_t pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  sent_per_mode[N_MODES];
    int  sat_seen = 0;
    int  dz_seen = 0;
    int  cycles = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_stalls = 1'b1;
    bit  hold_request = 1'b0;

    complex_arithmetic_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_a_re      (s_a_re),
        .s_a_im      (s_a_im),
        .s_b_re      (s_b_re),
        .s_b_im      (s_b_im),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res_re    (m_res_re),
        .m_res_im    (m_res_im),
        .m_div_zero  (m_div_zero),
        .m_saturated (m_saturated)
    );

    // 10 ns clock: high half, then low half.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // Clamp an exact value into the word range; note clamping in sat.
    function automatic word_t clamp_word(input wide_t v, inout logic sat);
        wide_t hi_lim, lo_lim;
        hi_lim = (wide_t'(1) <<< (DATA_W - 1)) - 1;
        lo_lim = -(wide_t'(1) <<< (DATA_W - 1));
        if (v > hi_lim) begin
            sat = 1'b1;
            return MAX_VAL;
        end
        if (v < lo_lim) begin
            sat = 1'b1;
            return MIN_VAL;
        end
        return v[DATA_W-1:0];
    endfunction

    // Drop fraction bits with truncation toward zero.
    function automatic wide_t shift_toward_zero(input wide_t v, input int s);
        if (v < 0) return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] n);
        logic [127:0] root, bit_pos;
        root = '0;
        bit_pos = 128'd1 << 126;
        while (bit_pos > n) bit_pos = bit_pos >> 2;
        while (bit_pos != 0) begin
            if (n >= root + bit_pos) begin
                n = n - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end else begin
                root = root >> 1;
            end
            bit_pos = bit_pos >> 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC angle of (x, y) in Q34.30 radians.
    function automatic longint cordic_angle(input longint x, input longint y);
        longint z, t, dx, dy;
        longint norm_lim;
        norm_lim = 64'sh0800_0000_0000_0000;
        z = 0;
        if (x == 0 && y == 0) return 0;
        // Pre-rotate into the right half plane.
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(HALF_PI_Q30);
            end else begin
                x = -y;
                y = t;
                z = -longint'(HALF_PI_Q30);
            end
        end
        while (x < norm_lim && y < norm_lim && y > -norm_lim) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x = x + dy;
                y = y - dx;
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic alu_result_t predict_alu(input mode_t mode, input word_t ar,
                                                input word_t ai, input word_t br,
                                                input word_t bi);
        alu_result_t r;
        wide_t wr, wi, den;
        logic sat;
        sat = 1'b0;
        r.mode = mode;
        r.re = '0;
        r.im = '0;
        r.dz = 1'b0;
        case (mode)
            MODE_ADD: begin
                r.re = clamp_word(wide_t'(ar) + wide_t'(br), sat);
                r.im = clamp_word(wide_t'(ai) + wide_t'(bi), sat);
            end
            MODE_SUB: begin
                r.re = clamp_word(wide_t'(ar) - wide_t'(br), sat);
                r.im = clamp_word(wide_t'(ai) - wide_t'(bi), sat);
            end
            MODE_MUL: begin
                wr = wide_t'(ar) * wide_t'(br) - wide_t'(ai) * wide_t'(bi);
                wi = wide_t'(ar) * wide_t'(bi) + wide_t'(ai) * wide_t'(br);
                r.re = clamp_word(shift_toward_zero(wr, FRAC_W), sat);
                r.im = clamp_word(shift_toward_zero(wi, FRAC_W), sat);
            end
            MODE_DIV: begin
                den = wide_t'(br) * wide_t'(br) + wide_t'(bi) * wide_t'(bi);
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    wr = (wide_t'(ar) * wide_t'(br) + wide_t'(ai) * wide_t'(bi)) <<< FRAC_W;
                    wi = (wide_t'(ai) * wide_t'(br) - wide_t'(ar) * wide_t'(bi)) <<< FRAC_W;
                    r.re = clamp_word(wr / den, sat);
                    r.im = clamp_word(wi / den, sat);
                end
            end
            MODE_MAG: begin
                wr = wide_t'(ar) * wide_t'(ar) + wide_t'(ai) * wide_t'(ai);
                r.re = clamp_word(wide_t'(int_sqrt(wr)), sat);
            end
            MODE_PHASE: begin
                wr = wide_t'(cordic_angle(longint'(ar), longint'(ai)));
                r.re = clamp_word(shift_toward_zero(wr, ANGLE_FRAC - FRAC_W), sat);
            end
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one operation; hold it until the transfer, then queue its result.
    task automatic send_op(input mode_t mode, input word_t ar, input word_t ai,
                           input word_t br, input word_t bi);
        int gap;
        gap = sender_idles ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_a_re  <= ar;
        s_a_im  <= ai;
        s_b_re  <= br;
        s_b_im  <= bi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_alu(mode, ar, ai, br, bi));
        sent_per_mode[mode]++;
    endtask

    // Mix of full-range, right-shifted, small Q16.16, whole-number and boundary operands.
    function automatic word_t rand_operand();
        case ($urandom_range(0, 5))
            0, 1: return word_t'($urandom);
            2:    return word_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            3:    return word_t'($urandom) >>> $urandom_range(0, 31);
            4: begin
                case ($urandom_range(0, 4))
                    0: return MAX_VAL;
                    1: return MIN_VAL;
                    2: return '0;
                    3: return word_t'(1);
                    default: return word_t'(-1);
                endcase
            end
            default: return word_t'($signed($urandom_range(0, 64)) - 32) <<< FRAC_W;
        endcase
    endfunction

    task automatic send_random(input int count);
        mode_t mode;
        word_t br, bi;
        for (int n = 0; n < count; n++) begin
            mode = mode_t'($urandom_range(0, N_MODES - 1));
            br = rand_operand();
            bi = rand_operand();
            // Force a zero divisor now and then.
            if (mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_op(mode, rand_operand(), rand_operand(), br, bi);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Draw a stall before each result; serve a long hold-off when asked.
    initial begin : result_pacer
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            stall = receiver_stalls ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result re=%h im=%h", m_res_re, m_res_im);
            end else begin
                want = pending_results.pop_front();
                if (want.sat) sat_seen++;
                if (want.dz) dz_seen++;
                if (m_res_re !== want.re || m_res_im !== want.im ||
                    m_div_zero !== want.dz || m_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Mismatch %s: want re=%h im=%h dz=%b sat=%b",
                                 want.mode.name(), want.re, want.im, want.dz, want.sat);
                        $display("    got re=%h im=%h dz=%b sat=%b",
                                 m_res_re, m_res_im, m_div_zero, m_saturated);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_corners();
        for (int m = 0; m < N_MODES; m++) begin
            send_op(mode_t'(m), MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL);
            send_op(mode_t'(m), MIN_VAL, MAX_VAL, word_t'(-1), word_t'(1));
        end
        // Divide by zero, and zero vector phase and magnitude.
        send_op(MODE_DIV, 32'sh0001_0000, 32'sh0002_0000, '0, '0);
        send_op(MODE_PHASE, '0, '0, '0, '0);
        send_op(MODE_MAG, '0, '0, '0, '0);
        // Phase in the left-half quadrants and on the negative axes.
        send_op(MODE_PHASE, -32'sh0001_0000, 32'sh0001_0000, '0, '0);
        send_op(MODE_PHASE, -32'sh0001_0000, -32'sh0001_0000, '0, '0);
        send_op(MODE_PHASE, -32'sh0001_0000, '0, '0, '0);
        send_op(MODE_PHASE, '0, MIN_VAL, '0, '0);
        // Plain values and sign mixes for the truncating paths.
        send_op(MODE_MUL, 32'sh0001_8000, -32'sh0000_0003, 32'sh0000_0001, 32'sh0002_0000);
        send_op(MODE_DIV, 32'sh0003_0000, -32'sh0001_0000, 32'sh0000_0001, '0);
        send_op(MODE_DIV, 32'sh0001_0000, 32'sh0000_0001, 32'sh0003_0000, 32'sh0000_0007);
        send_op(MODE_MAG, MIN_VAL, MIN_VAL, '0, '0);
        send_op(MODE_SUB, MIN_VAL, '0, 32'sh0000_0001, MIN_VAL);
    endtask

    task automatic test_random_mix();
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        send_random(450);
    endtask

    // Long receiver hold-off while input keeps coming: fills the pipe.
    task automatic test_backpressure();
        sender_idles = 1'b0;
        hold_request = 1'b1;
        send_random(150);
        sender_idles = 1'b1;
    endtask

    // Back-to-back on both sides.
    task automatic test_streaming();
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        send_random(130);
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial begin : run
        foreach (sent_per_mode[m]) sent_per_mode[m] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corners();
        test_random_mix();
        test_backpressure();
        test_streaming();
        s_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered add %0d, sub %0d, mul %0d, div %0d, mag %0d, phase %0d ops",
                 sent_per_mode[MODE_ADD], sent_per_mode[MODE_SUB], sent_per_mode[MODE_MUL],
                 sent_per_mode[MODE_DIV], sent_per_mode[MODE_MAG], sent_per_mode[MODE_PHASE]);
        $display("%0d results checked (%0d clamped, %0d zero divisor), %0d mismatches",
                 results_seen, sat_seen, dz_seen, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
